/* sv/blpw_pkg.sv */
// Shared types and constants for the Bresenham line pixel writer.
package blpw_pkg;

   localparam int COORD_BITS_DEF = 12;
   localparam int COLOR_BITS_DEF = 16;
   localparam int ADDR_BITS      = 32;
   localparam int PITCH_BITS     = 16;
   localparam int CSR_ADDR_BITS  = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam int QUEUE_DEPTH    = 4;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_TICK  = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      REG_FRAME_BASE    = 2'd0,
      REG_ROW_PITCH     = 2'd1,
      REG_SCREEN_HEIGHT = 2'd2,
      REG_BUFFER_SELECT = 2'd3
   } csr_reg_type;

   typedef struct packed {
      logic valid;
      logic last;
   } pix_ctl_type;

endpackage

/* sv/bresenham_line_pixel_writer.sv */
// Top level of the Bresenham line pixel writer: register port, queue, engine, address pipe.
// Takes one request word per clock while the queue has room, and returns at most one pixel
// write per request. A start word emits the line's first pixel, each tick word while a line
// is active emits the next one, and the endpoint pixel carries tlast. The sustained rate
// is one word per clock while the response side accepts, set by the Bresenham step in the
// line engine. A four-word queue sits in front of the engine so the request side keeps
// flowing while the response side stalls, until the queue fills. Registers take effect for
// pixels emitted after the write; write them only while no line is in flight.
module bresenham_line_pixel_writer import blpw_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COLOR_BITS = COLOR_BITS_DEF,
   localparam int REQ_DATA_BITS = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((ADDR_BITS + COLOR_BITS + 2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // x_start, y_start, x_end, y_end, color
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   // req_type
   input  logic                     req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // pixel_address, pixel_color, pixel_x, pixel_y
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tlast,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [ADDR_BITS-1:0]  frame_base_ff;
   logic [PITCH_BITS-1:0] row_pitch_ff;
   logic [COORD_BITS-1:0] screen_height_ff;
   logic                  buffer_select_ff;
   logic                  csr_write;
   csr_reg_type           csr_reg;

   logic                  push, advance, q_valid, q_pop;
   req_kind_type          q_kind;
   logic [COORD_BITS-1:0] q_x0, q_y0, q_x1, q_y1;
   logic [COLOR_BITS-1:0] q_color;
   pix_ctl_type           pix_ctl;
   logic [COORD_BITS-1:0] pix_x, pix_y;
   logic [COLOR_BITS-1:0] pix_color;
   logic [ADDR_BITS-1:0]  out_address;
   logic [COLOR_BITS-1:0] out_color;
   logic [COORD_BITS-1:0] out_x, out_y;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_reg_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff    <= '0;
         row_pitch_ff     <= '0;
         screen_height_ff <= '0;
         buffer_select_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_reg)
            REG_FRAME_BASE:    frame_base_ff    <= csr_pwdata[ADDR_BITS-1:0];
            REG_ROW_PITCH:     row_pitch_ff     <= csr_pwdata[PITCH_BITS-1:0];
            REG_SCREEN_HEIGHT: screen_height_ff <= csr_pwdata[COORD_BITS-1:0];
            REG_BUFFER_SELECT: buffer_select_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         REG_FRAME_BASE:    csr_prdata = CSR_DATA_BITS'(frame_base_ff);
         REG_ROW_PITCH:     csr_prdata = CSR_DATA_BITS'(row_pitch_ff);
         REG_SCREEN_HEIGHT: csr_prdata = CSR_DATA_BITS'(screen_height_ff);
         REG_BUFFER_SELECT: csr_prdata = CSR_DATA_BITS'(buffer_select_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign push = req_tvalid && req_tready;

   blpw_front #(
      .COORD_BITS(COORD_BITS),
      .COLOR_BITS(COLOR_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_type  (req_tuser),
      .push_x0    (req_tdata[0 +: COORD_BITS]),
      .push_y0    (req_tdata[COORD_BITS +: COORD_BITS]),
      .push_x1    (req_tdata[2 * COORD_BITS +: COORD_BITS]),
      .push_y1    (req_tdata[3 * COORD_BITS +: COORD_BITS]),
      .push_color (req_tdata[4 * COORD_BITS +: COLOR_BITS]),
      .can_push   (req_tready),
      .pop        (q_pop),
      .q_valid    (q_valid),
      .q_kind     (q_kind),
      .q_x0       (q_x0),
      .q_y0       (q_y0),
      .q_x1       (q_x1),
      .q_y1       (q_y1),
      .q_color    (q_color)
   );

   blpw_engine #(
      .COORD_BITS(COORD_BITS),
      .COLOR_BITS(COLOR_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .q_valid   (q_valid),
      .q_kind    (q_kind),
      .q_x0      (q_x0),
      .q_y0      (q_y0),
      .q_x1      (q_x1),
      .q_y1      (q_y1),
      .q_color   (q_color),
      .q_pop     (q_pop),
      .pix_ctl   (pix_ctl),
      .pix_x     (pix_x),
      .pix_y     (pix_y),
      .pix_color (pix_color)
   );

   blpw_addr #(
      .COORD_BITS(COORD_BITS),
      .COLOR_BITS(COLOR_BITS)
   ) u_addr (
      .clock         (clock),
      .reset         (reset),
      .pix_ctl       (pix_ctl),
      .pix_x         (pix_x),
      .pix_y         (pix_y),
      .pix_color     (pix_color),
      .frame_base    (frame_base_ff),
      .row_pitch     (row_pitch_ff),
      .screen_height (screen_height_ff),
      .buffer_select (buffer_select_ff),
      .advance       (advance),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_address   (out_address),
      .out_color     (out_color),
      .out_x         (out_x),
      .out_y         (out_y),
      .out_last      (rsp_tlast)
   );

   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[0 +: ADDR_BITS] = out_address;
      rsp_tdata[ADDR_BITS +: COLOR_BITS] = out_color;
      rsp_tdata[ADDR_BITS + COLOR_BITS +: COORD_BITS] = out_x;
      rsp_tdata[ADDR_BITS + COLOR_BITS + COORD_BITS +: COORD_BITS] = out_y;
   end

endmodule

/* sv/blpw_front.sv */
// Input front end: decode the request kind and queue words for the line engine.
module blpw_front import blpw_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COLOR_BITS = COLOR_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic                  push_type,
   input  logic [COORD_BITS-1:0] push_x0,
   input  logic [COORD_BITS-1:0] push_y0,
   input  logic [COORD_BITS-1:0] push_x1,
   input  logic [COORD_BITS-1:0] push_y1,
   input  logic [COLOR_BITS-1:0] push_color,
   output logic                  can_push,
   input  logic                  pop,
   output logic                  q_valid,
   output req_kind_type          q_kind,
   output logic [COORD_BITS-1:0] q_x0,
   output logic [COORD_BITS-1:0] q_y0,
   output logic [COORD_BITS-1:0] q_x1,
   output logic [COORD_BITS-1:0] q_y1,
   output logic [COLOR_BITS-1:0] q_color
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int ITEM_BITS = 1 + 4 * COORD_BITS + COLOR_BITS;

   logic [ITEM_BITS-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [ITEM_BITS-1:0] head;
   req_kind_type         push_kind;

   assign push_kind = (push_type == 1'b1) ? KIND_TICK : KIND_START;
   assign can_push  = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   assign q_kind  = (head[0] == 1'b1) ? KIND_TICK : KIND_START;
   assign q_x0    = head[1 +: COORD_BITS];
   assign q_y0    = head[1 + COORD_BITS +: COORD_BITS];
   assign q_x1    = head[1 + 2 * COORD_BITS +: COORD_BITS];
   assign q_y1    = head[1 + 3 * COORD_BITS +: COORD_BITS];
   assign q_color = head[1 + 4 * COORD_BITS +: COLOR_BITS];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= {push_color, push_y1, push_x1, push_y0, push_x0, push_kind};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count past depth");
   assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not advance on push");

endmodule

/* sv/blpw_engine.sv */
// Line engine: Bresenham setup on start words and one step per tick word while a line is active.
module blpw_engine import blpw_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COLOR_BITS = COLOR_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  q_valid,
   input  req_kind_type          q_kind,
   input  logic [COORD_BITS-1:0] q_x0,
   input  logic [COORD_BITS-1:0] q_y0,
   input  logic [COORD_BITS-1:0] q_x1,
   input  logic [COORD_BITS-1:0] q_y1,
   input  logic [COLOR_BITS-1:0] q_color,
   output logic                  q_pop,
   output pix_ctl_type           pix_ctl,
   output logic [COORD_BITS-1:0] pix_x,
   output logic [COORD_BITS-1:0] pix_y,
   output logic [COLOR_BITS-1:0] pix_color
);

   localparam int ERR_BITS = COORD_BITS + 2;

   logic [COORD_BITS-1:0]      cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_BITS-1:0]      tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [COORD_BITS-1:0]      span_x_ff, span_x_in, span_y_ff, span_y_in;
   logic                       x_neg_ff, x_neg_in, y_neg_ff, y_neg_in;
   logic signed [ERR_BITS-1:0] err_ff, err_in;
   logic [COLOR_BITS-1:0]      color_ff, color_in;
   logic                       busy_ff, busy_in;
   pix_ctl_type                pix_ctl_ff, pix_ctl_in;
   logic [COORD_BITS-1:0]      pix_x_ff, pix_y_ff;
   logic [COLOR_BITS-1:0]      pix_color_ff;

   logic                       x_lt, y_lt, step_x, step_y;
   logic [COORD_BITS-1:0]      sx_new, sy_new;
   logic signed [ERR_BITS-1:0] sx_s, sy_s, half_x, half_y;

   assign q_pop = advance && q_valid;

   always_comb begin
      x_lt   = q_x0 < q_x1;
      y_lt   = q_y0 < q_y1;
      sx_new = x_lt ? q_x1 - q_x0 : q_x0 - q_x1;
      sy_new = y_lt ? q_y1 - q_y0 : q_y0 - q_y1;
      half_x = signed'({2'b00, sx_new >> 1});
      half_y = signed'({2'b00, sy_new >> 1});
      sx_s   = signed'({2'b00, span_x_ff});
      sy_s   = signed'({2'b00, span_y_ff});
      step_x = err_ff > -sx_s;
      step_y = err_ff < sy_s;

      cur_x_in   = cur_x_ff;
      cur_y_in   = cur_y_ff;
      tgt_x_in   = tgt_x_ff;
      tgt_y_in   = tgt_y_ff;
      span_x_in  = span_x_ff;
      span_y_in  = span_y_ff;
      x_neg_in   = x_neg_ff;
      y_neg_in   = y_neg_ff;
      err_in     = err_ff;
      color_in   = color_ff;
      busy_in    = busy_ff;
      pix_ctl_in = '0;

      if (q_pop && q_kind == KIND_START) begin
         cur_x_in  = q_x0;
         cur_y_in  = q_y0;
         tgt_x_in  = q_x1;
         tgt_y_in  = q_y1;
         span_x_in = sx_new;
         span_y_in = sy_new;
         x_neg_in  = !x_lt;
         y_neg_in  = !y_lt;
         err_in    = (sx_new > sy_new) ? half_x : -half_y;
         color_in  = q_color;
         pix_ctl_in.valid = 1'b1;
      end else if (q_pop && busy_ff) begin
         err_in = err_ff - (step_x ? sy_s : '0) + (step_y ? sx_s : '0);
         if (step_x) begin
            cur_x_in = x_neg_ff ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
         end
         if (step_y) begin
            cur_y_in = y_neg_ff ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
         end
         pix_ctl_in.valid = 1'b1;
      end

      if (pix_ctl_in.valid) begin
         pix_ctl_in.last = (cur_x_in == tgt_x_in) && (cur_y_in == tgt_y_in);
         busy_in         = !pix_ctl_in.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff   <= '0;
         cur_y_ff   <= '0;
         tgt_x_ff   <= '0;
         tgt_y_ff   <= '0;
         span_x_ff  <= '0;
         span_y_ff  <= '0;
         x_neg_ff   <= 1'b0;
         y_neg_ff   <= 1'b0;
         err_ff     <= '0;
         color_ff   <= '0;
         busy_ff    <= 1'b0;
         pix_ctl_ff <= '0;
      end else if (advance) begin
         cur_x_ff   <= cur_x_in;
         cur_y_ff   <= cur_y_in;
         tgt_x_ff   <= tgt_x_in;
         tgt_y_ff   <= tgt_y_in;
         span_x_ff  <= span_x_in;
         span_y_ff  <= span_y_in;
         x_neg_ff   <= x_neg_in;
         y_neg_ff   <= y_neg_in;
         err_ff     <= err_in;
         color_ff   <= color_in;
         busy_ff    <= busy_in;
         pix_ctl_ff <= pix_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pix_x_ff     <= cur_x_in;
         pix_y_ff     <= cur_y_in;
         pix_color_ff <= color_in;
      end
   end

   assign pix_ctl   = pix_ctl_ff;
   assign pix_x     = pix_x_ff;
   assign pix_y     = pix_y_ff;
   assign pix_color = pix_color_ff;

   assert property (@(posedge clock) disable iff (reset)
      q_pop && q_kind == KIND_START |=> pix_ctl_ff.valid)
      else $error("start word produced no pixel");
   assert property (@(posedge clock) disable iff (reset)
      q_pop && q_kind == KIND_TICK && !busy_ff |=> !pix_ctl_ff.valid)
      else $error("idle tick produced a pixel");
   assert property (@(posedge clock) disable iff (reset)
      pix_ctl_ff.valid |-> busy_ff == !pix_ctl_ff.last)
      else $error("busy flag disagrees with last pixel");

endmodule

/* sv/blpw_addr.sv */
// Address pipeline: row times pitch, then base and column offset into the output register.
module blpw_addr import blpw_pkg::*; #(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COLOR_BITS = COLOR_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pix_ctl_type           pix_ctl,
   input  logic [COORD_BITS-1:0] pix_x,
   input  logic [COORD_BITS-1:0] pix_y,
   input  logic [COLOR_BITS-1:0] pix_color,
   input  logic [ADDR_BITS-1:0]  frame_base,
   input  logic [PITCH_BITS-1:0] row_pitch,
   input  logic [COORD_BITS-1:0] screen_height,
   input  logic                  buffer_select,
   output logic                  advance,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [ADDR_BITS-1:0]  out_address,
   output logic [COLOR_BITS-1:0] out_color,
   output logic [COORD_BITS-1:0] out_x,
   output logic [COORD_BITS-1:0] out_y,
   output logic                  out_last
);

   localparam int ROW_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS = ROW_BITS + PITCH_BITS;

   logic [ROW_BITS-1:0]   row;
   logic [PROD_BITS-1:0]  prod_in;
   pix_ctl_type           s2_ctl_ff;
   logic [PROD_BITS-1:0]  s2_prod_ff;
   logic [COORD_BITS-1:0] s2_x_ff, s2_y_ff;
   logic [COLOR_BITS-1:0] s2_color_ff;
   logic [ADDR_BITS-1:0]  addr_in;
   logic                  out_valid_ff;
   logic [ADDR_BITS-1:0]  out_address_ff;
   logic [COLOR_BITS-1:0] out_color_ff;
   logic [COORD_BITS-1:0] out_x_ff, out_y_ff;
   logic                  out_last_ff;

   assign advance = !out_valid_ff || out_ready;

   always_comb begin
      row     = ROW_BITS'(pix_y) + (buffer_select ? ROW_BITS'(screen_height) : '0);
      prod_in = PROD_BITS'(row) * PROD_BITS'(row_pitch);
      addr_in = frame_base + ADDR_BITS'(s2_prod_ff)
              + (ADDR_BITS'(s2_x_ff) << 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ctl_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_ctl_ff    <= pix_ctl;
         out_valid_ff <= s2_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_prod_ff     <= prod_in;
         s2_x_ff        <= pix_x;
         s2_y_ff        <= pix_y;
         s2_color_ff    <= pix_color;
         out_address_ff <= addr_in;
         out_color_ff   <= s2_color_ff;
         out_x_ff       <= s2_x_ff;
         out_y_ff       <= s2_y_ff;
         out_last_ff    <= s2_ctl_ff.last;
      end
   end

   assign out_valid   = out_valid_ff;
   assign out_address = out_address_ff;
   assign out_color   = out_color_ff;
   assign out_x       = out_x_ff;
   assign out_y       = out_y_ff;
   assign out_last    = out_last_ff;

   assert property (@(posedge clock) disable iff (reset)
      advance && s2_ctl_ff.valid |=> out_valid_ff)
      else $error("pixel lost between product and output stage");
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s2_ctl_ff) && $stable(s2_prod_ff))
      else $error("product stage moved during stall");
   assert property (@(posedge clock) disable iff (reset)
      advance && !s2_ctl_ff.valid |=> !out_valid_ff)
      else $error("output word without a source pixel");

endmodule

/* verif/bresenham_line_pixel_writer_test.sv */
// Self-checking testbench for the Bresenham line pixel writer: directed table, then random lines.
`timescale 1ns / 100ps

module bresenham_line_pixel_writer_test;
   import blpw_pkg::*;

   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [31:0] addr;
      logic [15:0] color;
      logic [11:0] x;
      logic [11:0] y;
      logic        last;
   } pixel_write_type;

   typedef enum logic {
      OP_WORD = 1'b0,
      OP_CSR  = 1'b1
   } plan_op_type;

   typedef struct packed {
      plan_op_type  op;
      req_kind_type kind;
      logic [11:0]  x0;
      logic [11:0]  y0;
      logic [11:0]  x1;
      logic [11:0]  y1;
      logic [15:0]  ink;
      csr_reg_type  sel;
      logic [31:0]  value;
      logic         typed;
      logic         hit;
      logic [31:0]  addr;
      logic         last;
   } plan_row_type;

   localparam plan_row_type DIRECTED [25] = '{
      '{OP_WORD, KIND_TICK,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000,
        REG_FRAME_BASE, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_START, 12'd0,    12'd0,    12'd0,    12'd0,    16'hFFFF,
        REG_FRAME_BASE, 32'h0, 1'b1, 1'b1, 32'h0, 1'b1},
      '{OP_WORD, KIND_TICK,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000,
        REG_FRAME_BASE, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_START, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'h0000,
        REG_FRAME_BASE, 32'h0, 1'b1, 1'b1, 32'd8190, 1'b1},
      '{OP_WORD, KIND_START, 12'd0,    12'd0,    12'd3,    12'd1,    16'h1234,
        REG_FRAME_BASE, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_TICK,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000,
        REG_FRAME_BASE, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_TICK,  12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'hFFFF,
        REG_FRAME_BASE, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_TICK,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000,
        REG_FRAME_BASE, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_START, 12'd10,   12'd10,   12'd0,    12'd20,   16'hABCD,
        REG_FRAME_BASE, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_TICK,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000,
        REG_FRAME_BASE, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_START, 12'd4095, 12'd0,    12'd4092, 12'd3,    16'h5A5A,
        REG_FRAME_BASE, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_TICK,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000,
        REG_FRAME_BASE, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_TICK,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000,
        REG_FRAME_BASE, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_TICK,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000,
        REG_FRAME_BASE, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_START, 12'd5,    12'd9,    12'd3,    12'd0,    16'h00FF,
        REG_FRAME_BASE, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_TICK,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000,
        REG_FRAME_BASE, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_TICK,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000,
        REG_FRAME_BASE, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_START, 12'd0,    12'd4095, 12'd4095, 12'd0,    16'hC3C3,
        REG_FRAME_BASE, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_START, 12'd100,  12'd200,  12'd100,  12'd200,  16'h7E7E,
        REG_FRAME_BASE, 32'h0, 1'b1, 1'b1, 32'd200, 1'b1},
      '{OP_CSR,  KIND_TICK,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000,
        REG_FRAME_BASE, 32'hFFFFFFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_CSR,  KIND_TICK,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000,
        REG_ROW_PITCH, 32'h0000FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_CSR,  KIND_TICK,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000,
        REG_SCREEN_HEIGHT, 32'h00000FFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_CSR,  KIND_TICK,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000,
        REG_BUFFER_SELECT, 32'h00000001, 1'b0, 1'b0, 32'h0, 1'b0},
      '{OP_WORD, KIND_START, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 16'h8001,
        REG_FRAME_BASE, 32'h0, 1'b1, 1'b1, 32'h1FFDFFFF, 1'b1},
      '{OP_WORD, KIND_TICK,  12'd0,    12'd0,    12'd0,    12'd0,    16'h0000,
        REG_FRAME_BASE, 32'h0, 1'b1, 1'b0, 32'h0, 1'b0}
   };

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   // x_start, y_start, x_end, y_end, color
   logic [63:0] req_tdata   = '0;
   // req_type
   logic        req_tuser   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   // pixel_address, pixel_color, pixel_x, pixel_y
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   pixel_write_type pixel_q [$];
   int mismatches   = 0;
   int words_drawn  = 0;
   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   int hold_left    = 0;
   int idle_cycles  = 0;

   logic [31:0] base_addr = '0;
   logic [15:0] pitch     = '0;
   logic [11:0] height    = '0;
   logic        use_back  = 1'b0;

   logic [11:0] pen_x  = '0;
   logic [11:0] pen_y  = '0;
   logic [11:0] goal_x = '0;
   logic [11:0] goal_y = '0;
   logic [11:0] run_x  = '0;
   logic [11:0] run_y  = '0;
   logic        x_back = 1'b0;
   logic        y_back = 1'b0;
   int          err_acc = 0;
   logic [15:0] ink     = '0;
   bit          drawing = 1'b0;

   bresenham_line_pixel_writer dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] pack_req(input logic [11:0] x0, input logic [11:0] y0,
                                            input logic [11:0] x1, input logic [11:0] y1,
                                            input logic [15:0] color);
      return {color, y1, x1, y0, x0};
   endfunction

   function automatic logic [11:0] nearby_coord(input logic [11:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 24)) - 12;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[11:0];
   endfunction

   // advance the line tracer by one word; returns 1 when a pixel write results
   function automatic bit trace_line(input req_kind_type kind, input logic [63:0] data,
                                     output pixel_write_type px);
      logic [11:0] x0, y0, x1, y1;
      logic [63:0] wide;
      int          e2;
      bit          last;
      x0 = data[11:0];
      y0 = data[23:12];
      x1 = data[35:24];
      y1 = data[47:36];
      px = '0;
      if (kind == KIND_START) begin
         pen_x   = x0;
         pen_y   = y0;
         goal_x  = x1;
         goal_y  = y1;
         run_x   = (x0 < x1) ? x1 - x0 : x0 - x1;
         run_y   = (y0 < y1) ? y1 - y0 : y0 - y1;
         x_back  = !(x0 < x1);
         y_back  = !(y0 < y1);
         err_acc = (run_x > run_y) ? int'(run_x / 2) : -int'(run_y / 2);
         ink     = data[63:48];
      end else if (!drawing) begin
         return 1'b0;
      end else begin
         e2 = err_acc;
         if (e2 > -int'(run_x)) begin
            err_acc -= int'(run_y);
            pen_x = x_back ? pen_x - 12'd1 : pen_x + 12'd1;
         end
         if (e2 < int'(run_y)) begin
            err_acc += int'(run_x);
            pen_y = y_back ? pen_y - 12'd1 : pen_y + 12'd1;
         end
      end
      last    = (pen_x == goal_x) && (pen_y == goal_y);
      drawing = !last;
      wide = 64'(base_addr) + (64'(pen_y) + (use_back ? 64'(height) : 64'd0)) * 64'(pitch)
             + 64'(pen_x) * 2;
      px.addr  = wide[31:0];
      px.color = ink;
      px.x     = pen_x;
      px.y     = pen_y;
      px.last  = last;
      return 1'b1;
   endfunction

   task automatic send_word(input req_kind_type kind, input logic [63:0] data,
                            input bit typed, input bit hit, input pixel_write_type typed_px);
      pixel_write_type px;
      bit              made;
      while (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      do @(posedge clock); while (!req_tready);
      made = trace_line(kind, data, px);
      if (made) words_drawn++;
      if (typed ? hit : made) pixel_q.push_back(typed ? typed_px : px);
   endtask

   task automatic write_csr(input csr_reg_type sel, input logic [31:0] value);
      req_tvalid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {sel, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (sel)
         REG_FRAME_BASE:    base_addr = value;
         REG_ROW_PITCH:     pitch     = value[15:0];
         REG_SCREEN_HEIGHT: height    = value[11:0];
         REG_BUFFER_SELECT: use_back  = value[0];
         default: ;
      endcase
   endtask

   task automatic set_phase(input int tx_pct, input int rx_pct, input logic [31:0] fill);
      if (drawing) send_word(KIND_START, pack_req(12'd0, 12'd0, 12'd0, 12'd0, 16'h0),
                             1'b0, 1'b0, '0);
      write_csr(REG_FRAME_BASE,    (fill === 'x) ? $urandom : fill);
      write_csr(REG_ROW_PITCH,     (fill === 'x) ? $urandom : fill);
      write_csr(REG_SCREEN_HEIGHT, (fill === 'x) ? $urandom : fill);
      write_csr(REG_BUFFER_SELECT, (fill === 'x) ? $urandom : fill);
      tx_idle_pct  = tx_pct;
      rx_stall_pct = rx_pct;
   endtask

   task automatic draw_lines(input int count);
      int          goal, roll, len, steps;
      logic [11:0] x0, y0, x1, y1;
      goal = words_drawn + count;
      while (words_drawn < goal) begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            send_word(req_kind_type'(1'($urandom_range(0, 1))), {$urandom, $urandom},
                      1'b0, 1'b0, '0);
         end else begin
            x0 = $urandom_range(0, 4095);
            y0 = $urandom_range(0, 4095);
            if (roll < 20) begin
               x1 = $urandom_range(0, 4095);
               y1 = $urandom_range(0, 4095);
            end else begin
               x1 = nearby_coord(x0);
               y1 = nearby_coord(y0);
            end
            send_word(KIND_START, pack_req(x0, y0, x1, y1, 16'($urandom)), 1'b0, 1'b0, '0);
            len = (x0 < x1) ? int'(x1 - x0) : int'(x0 - x1);
            if (((y0 < y1) ? int'(y1 - y0) : int'(y0 - y1)) > len)
               len = (y0 < y1) ? int'(y1 - y0) : int'(y0 - y1);
            roll  = $urandom_range(0, 9);
            steps = len;
            if (roll == 0) steps = $urandom_range(0, len);
            else if (roll == 1) steps = len + $urandom_range(1, 3);
            if (steps > 60) steps = $urandom_range(10, 60);
            repeat (steps) send_word(KIND_TICK, {$urandom, $urandom}, 1'b0, 1'b0, '0);
         end
      end
   endtask

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(1, 100) > rx_stall_pct);
      end
   end

   always @(posedge clock) begin : pixel_check
      pixel_write_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_q.size() == 0) begin
            flag_mismatch("unexpected pixel address", rsp_tdata[31:0], '0);
         end else begin
            want = pixel_q.pop_front();
            if (rsp_tdata[31:0] !== want.addr)
               flag_mismatch("pixel_address", rsp_tdata[31:0], want.addr);
            if (rsp_tdata[47:32] !== want.color)
               flag_mismatch("pixel_color", 32'(rsp_tdata[47:32]), 32'(want.color));
            if (rsp_tdata[59:48] !== want.x)
               flag_mismatch("pixel_x", 32'(rsp_tdata[59:48]), 32'(want.x));
            if (rsp_tdata[71:60] !== want.y)
               flag_mismatch("pixel_y", 32'(rsp_tdata[71:60]), 32'(want.y));
            if (rsp_tlast !== want.last)
               flag_mismatch("last_pixel", 32'(rsp_tlast), 32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_psel && csr_penable))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL bresenham_line_pixel_writer");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].op == OP_CSR)
            write_csr(DIRECTED[i].sel, DIRECTED[i].value);
         else
            send_word(DIRECTED[i].kind,
                      pack_req(DIRECTED[i].x0, DIRECTED[i].y0, DIRECTED[i].x1,
                               DIRECTED[i].y1, DIRECTED[i].ink),
                      DIRECTED[i].typed, DIRECTED[i].hit,
                      '{addr: DIRECTED[i].addr, color: DIRECTED[i].ink, x: DIRECTED[i].x0,
                        y: DIRECTED[i].y0, last: DIRECTED[i].last});
      end

      set_phase(0, 0, 'x);
      draw_lines(90);
      hold_left = 300;
      draw_lines(80);

      set_phase(58, 0, '0);
      draw_lines(90);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pixel_q.size() != 0);
      draw_lines(80);

      set_phase(0, 58, 'x);
      draw_lines(170);

      set_phase(38, 38, '1);
      draw_lines(170);

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pixel_q.size() != 0);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("PASS bresenham_line_pixel_writer");
      else
         $display("FAIL bresenham_line_pixel_writer");
      $finish;
   end

endmodule
